// ----- rtl/core/sle_pkg.sv -----
// Shared constants and types of the sequential list engine.
package sle_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    // Largest supported list; sizes the shared index fields.
    localparam int CAP_MAX = 1024;
    localparam int IDX_W   = $clog2(CAP_MAX + 2);

    // Match bits examined per cycle by the locate scan.
    localparam int GROUP = 8;
    localparam int BIT_W = $clog2(GROUP);

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd2;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos_idx;
        logic [IDX_W-1:0] count;
    } t_cell_cmd;

    // Status of the locate scan.
    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] pos_idx;
    } t_scan_res;

endpackage

// ----- rtl/core/sequential_list_engine.sv -----
// Top level of the sequential list engine: a chain of element cells, a locate scan and the result register.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_mode, i_position, i_value
//   result    out        o_valid / i_stall    o_ok, o_removed_value, o_found_position,
//                                             o_list_length
//
// Insert, delete and unused modes finish in the cycle of their transfer: the cell chain
// shifts in parallel and the result register loads at that same edge.
// Locate: the cells compare in parallel at the transfer edge, then the scan walks the
// match bits eight per cycle to the first hit.
// Reset (synchronous, active low) empties the list and the result register; element
// contents are not cleared, since only occupied slots are ever read.
// The input is stalled while a locate scan runs, and while the result register holds
// a result that the receiver is stalling.
module sequential_list_engine #(
    parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_position,
    input  logic [31:0] i_value,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [31:0] o_removed_value,
    output logic [6:0]  o_found_position,
    output logic [6:0]  o_list_length
);

    localparam int IDX_W  = sle_pkg::IDX_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int AIDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic             r_ok, n_ok;
    logic [31:0]      r_removed, n_removed;
    logic [6:0]       r_found, n_found;
    logic [6:0]       r_len, n_len;

    logic [ELEM_WIDTH-1:0] w_value;
    logic [ELEM_WIDTH-1:0] w_elem [CAPACITY];
    logic [CAPACITY-1:0]   w_match;
    logic [IDX_W-1:0]      w_count_x;
    logic [IDX_W-1:0]      w_pos_x;
    logic [IDX_W-1:0]      w_pos_idx;
    logic                  w_ins_ok;
    logic                  w_del_ok;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_is_locate;
    sle_pkg::t_cell_cmd    w_cmd;
    sle_pkg::t_scan_res    w_scan;

    // Elements keep the low ELEM_WIDTH bits of the incoming value.
    assign w_value   = ELEM_WIDTH'(i_value);
    assign w_count_x = IDX_W'(r_count);
    assign w_pos_x   = IDX_W'(i_position);
    assign w_pos_idx = w_pos_x - IDX_W'(1);

    assign w_is_locate = (i_mode == sle_pkg::MODE_LOCATE);

    // Insert needs a position in 1..length+1 and a free slot; delete needs 1..length.
    assign w_ins_ok = (i_mode == sle_pkg::MODE_INSERT) && (w_pos_x != '0)
                   && (w_pos_x <= w_count_x + IDX_W'(1))
                   && (w_count_x < IDX_W'(CAPACITY));
    assign w_del_ok = (i_mode == sle_pkg::MODE_DELETE) && (w_pos_x != '0)
                   && (w_pos_x <= w_count_x);

    // The result register can take a new result when empty or being emptied.
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == ST_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;

    assign w_cmd.ins     = w_accept && w_ins_ok;
    assign w_cmd.del     = w_accept && w_del_ok;
    assign w_cmd.pos_idx = w_pos_idx;
    assign w_cmd.count   = w_count_x;

    // The chain: each cell sees its lower and upper neighbor. The first cell never takes
    // from its lower neighbor, and the last one refills itself on a delete.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ELEM_WIDTH-1:0] w_left;
        logic [ELEM_WIDTH-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_elem[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_elem[k];
        end else begin : g_mid_r
            assign w_right = w_elem[k+1];
        end

        sle_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .INDEX      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_elem  (w_elem[k]),
            .o_match (w_match[k])
        );
    end

    sle_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && w_is_locate),
        .i_match (w_match),
        .o_res   (w_scan)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_ok        = r_ok;
        n_removed   = r_removed;
        n_found     = r_found;
        n_len       = r_len;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_is_locate) begin
                        n_state = ST_SCAN;
                    end else begin
                        // Insert, delete, or a mode with no operation.
                        if (w_ins_ok) begin
                            n_count = r_count + CNT_W'(1);
                        end else if (w_del_ok) begin
                            n_count = r_count - CNT_W'(1);
                        end
                        n_out_valid = 1'b1;
                        n_ok        = w_ins_ok || w_del_ok;
                        n_removed   = w_del_ok ? 32'(w_elem[w_pos_idx[AIDX_W-1:0]]) : '0;
                        n_found     = '0;
                        n_len       = 7'(n_count);
                    end
                end
            end
            ST_SCAN: begin
                if (w_scan.done && w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_ok        = w_scan.hit;
                    n_removed   = '0;
                    n_found     = w_scan.hit ? 7'(w_scan.pos_idx + IDX_W'(1)) : '0;
                    n_len       = 7'(r_count);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok      <= n_ok;
        r_removed <= n_removed;
        r_found   <= n_found;
        r_len     <= n_len;
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_ok;
    assign o_removed_value  = r_removed;
    assign o_found_position = r_found;
    assign o_list_length    = r_len;

endmodule

// ----- rtl/core/sle_cell.sv -----
// One storage cell of the list chain: holds one element and shifts with its neighbors.
module sle_cell #(
    parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  sle_pkg::t_cell_cmd    i_cmd,
    input  logic [ELEM_WIDTH-1:0] i_value,
    input  logic [ELEM_WIDTH-1:0] i_left,
    input  logic [ELEM_WIDTH-1:0] i_right,
    output logic [ELEM_WIDTH-1:0] o_elem,
    output logic                  o_match
);

    localparam logic [sle_pkg::IDX_W-1:0] MY_IDX = sle_pkg::IDX_W'(INDEX);

    logic [ELEM_WIDTH-1:0] r_elem;
    logic [ELEM_WIDTH-1:0] n_elem;

    // Insert loads the new value at its slot and moves later slots up;
    // delete pulls every slot from the deleted position onward down by one.
    always_comb begin
        n_elem = r_elem;
        if (i_cmd.ins) begin
            if (MY_IDX == i_cmd.pos_idx) begin
                n_elem = i_value;
            end else if (MY_IDX > i_cmd.pos_idx) begin
                n_elem = i_left;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_cmd.pos_idx) begin
                n_elem = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
    end

    assign o_elem  = r_elem;
    assign o_match = (MY_IDX < i_cmd.count) && (r_elem == i_value);

endmodule

// ----- rtl/core/sle_scan.sv -----
// Locate scan: captures the match bits of all cells and finds the first one, a group per cycle.
module sle_scan #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [CAPACITY-1:0] i_match,
    output sle_pkg::t_scan_res  o_res
);

    localparam int NGROUPS = (CAPACITY + sle_pkg::GROUP - 1) / sle_pkg::GROUP;
    localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int VEC_W   = NGROUPS * sle_pkg::GROUP;

    logic [VEC_W-1:0]              r_vec;
    logic [GRP_W-1:0]              r_grp;
    logic [sle_pkg::GROUP-1:0]     w_slice;
    logic [sle_pkg::BIT_W-1:0]     w_bit;
    logic                          w_hit;
    logic                          w_last;

    assign w_slice = r_vec[r_grp * sle_pkg::GROUP +: sle_pkg::GROUP];
    assign w_hit   = |w_slice;
    assign w_last  = (r_grp == GRP_W'(NGROUPS - 1));

    // Lowest set bit of the current group.
    always_comb begin
        w_bit = '0;
        for (int i = sle_pkg::GROUP - 1; i >= 0; i--) begin
            if (w_slice[i]) begin
                w_bit = sle_pkg::BIT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
        end else if (i_load) begin
            r_grp <= '0;
        end else if (!(w_hit || w_last)) begin
            r_grp <= r_grp + GRP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vec <= VEC_W'(i_match);
        end
    end

    assign o_res.done    = w_hit || w_last;
    assign o_res.hit     = w_hit;
    assign o_res.pos_idx = sle_pkg::IDX_W'({r_grp, w_bit});

endmodule
